### hdl/dmm_pkg.sv
// Package for the dense matrix multiply block: widths, codes, sequencer states.
`timescale 1ns / 1ps

package dmm_pkg;

    localparam int MAX_DIM_DEFAULT = 16;

    // Fixed field widths
    localparam int DIM_W     = 5;
    localparam int IDX_W     = 4;
    localparam int ELEM_W    = 16;
    localparam int MUL_W     = 2 * ELEM_W;
    localparam int PROD_W    = 40;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    // Result status
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_OUT_RANGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } dmm_state_t;

    // Zero acts as one, anything above the largest dimension saturates
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > max_dim)
            r = DIM_W'(max_dim);
        else
            r = v;
        return r;
    endfunction

endpackage

### hdl/dense_matrix_multiply.sv
// Dense matrix multiply: A and B element stores with one shared multiply-accumulate unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, row, col, value.
//   Command 0 writes an element of A, command 1 an element of B; writes
//   outside the configured sizes are dropped and never give a result.
//   Command 2 computes one element of A x B and gives one transaction on the
//   output channel (out_valid/out_ready): product in Q24.16 and status.
//   Status 1 with product 0 flags a row or column outside the sizes.
//   Configuration: cfg_we/cfg_index/cfg_data set rows_a, inner_size, cols_b; 0 reads as 1,
//   large values saturate. They must be written only while idle; the block does not check.
// Timing:
//   A compute streams the row of A and the column of
//   B from the two stores, one term per cycle through a registered read, a
//   registered multiply and the 40-bit accumulator, and the sum then goes
//   to the output register. The shared MAC serves one compute at a time:
//   no new input is taken until its result is loaded.
//   An out-of-range compute reaches the output register in the cycle after acceptance.
// Reset: control state and sizes (16, or MAX_DIM if smaller) are cleared;
//   the stores are not, and an entry must be written before it is used.
// Stall: a result held in the output register blocks all new input until
//   out_ready takes it.
`timescale 1ns / 1ps

module dense_matrix_multiply
    import dmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DIM_W-1:0]         cfg_data,
    // input transactions
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         command,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [ELEM_W-1:0] value,
    // result transactions
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PROD_W-1:0] product,
    output logic                     status
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AW + IDX_W + 1;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'((MAX_DIM < 16) ? MAX_DIM : 16);

    // ---------------------------------------------------------------
    // Size registers
    // ---------------------------------------------------------------
    logic [DIM_W-1:0] rows_a_reg, inner_reg, cols_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_RESET;
            inner_reg  <= DIM_RESET;
            cols_b_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_A:     rows_a_reg <= clamp_dim(cfg_data, MAX_DIM);
                CFG_INNER_SIZE: inner_reg  <= clamp_dim(cfg_data, MAX_DIM);
                CFG_COLS_B:     cols_b_reg <= clamp_dim(cfg_data, MAX_DIM);
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Decode of the incoming transaction
    // ---------------------------------------------------------------
    logic [DIM_W-1:0] row_x, col_x;
    logic             in_acc;
    logic             we_a, we_b;
    logic             start_ok, start_err;
    logic [PW-1:0]    wr_addr_full, a_base_full;
    logic [AW-1:0]    wr_addr;

    assign row_x  = {1'b0, row};
    assign col_x  = {1'b0, col};
    assign in_acc = in_valid && in_ready;

    assign we_a = in_acc && (command == CMD_WRITE_A)
                  && (row_x < rows_a_reg) && (col_x < inner_reg);
    assign we_b = in_acc && (command == CMD_WRITE_B)
                  && (row_x < inner_reg) && (col_x < cols_b_reg);
    assign start_ok  = in_acc && (command == CMD_COMPUTE)
                       && (row_x < rows_a_reg) && (col_x < cols_b_reg);
    assign start_err = in_acc && (command == CMD_COMPUTE)
                       && !((row_x < rows_a_reg) && (col_x < cols_b_reg));

    assign a_base_full  = PW'(row) * PW'(MAX_DIM);
    assign wr_addr_full = a_base_full + PW'(col);
    assign wr_addr      = wr_addr_full[AW-1:0];

    // ---------------------------------------------------------------
    // Element stores
    // ---------------------------------------------------------------
    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];
    logic signed [ELEM_W-1:0] a_q, b_q;
    logic [AW-1:0]            a_addr_reg, a_addr_next;
    logic [AW-1:0]            b_addr_reg, b_addr_next;

    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[wr_addr] <= value;
        a_q <= mem_a[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            mem_b[wr_addr] <= value;
        b_q <= mem_b[b_addr_reg];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    dmm_state_t       state_reg, state_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             mul_vld_reg;
    logic             issue;
    logic             out_free;
    logic             done_load;
    logic             out_valid_reg, out_valid_next;

    assign issue    = (state_reg == ST_RUN) && (k_reg < inner_reg);
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_ok)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!issue && !rd_vld_reg && !mul_vld_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready    = 1'b0;
        done_load   = 1'b0;
        rd_vld_next = 1'b0;
        k_next      = k_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = out_free;
                k_next      = '0;
                a_addr_next = a_base_full[AW-1:0];
                b_addr_next = AW'(col);
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    rd_vld_next = 1'b1;
                    k_next      = k_reg + DIM_W'(1);
                    a_addr_next = a_addr_reg + AW'(1);
                    b_addr_next = b_addr_reg + AW'(MAX_DIM);
                end
            end
            ST_DONE:
            begin
                done_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
    end

    // ---------------------------------------------------------------
    // Shared multiply-accumulate
    // ---------------------------------------------------------------
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [PROD_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        mul_reg <= a_q * b_q;
        if (start_ok)
            acc_reg <= '0;
        else if (mul_vld_reg)
            acc_reg <= acc_reg + PROD_W'(mul_reg);
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] product_reg;
    logic                     status_reg;

    always_comb
    begin
        if (done_load || start_err)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (start_err)
        begin
            product_reg <= '0;
            status_reg  <= STATUS_OUT_RANGE;
        end
        else if (done_load)
        begin
            product_reg <= acc_reg;
            status_reg  <= STATUS_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign status    = status_reg;

`ifndef SYNTH
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start_ok |=> (state_reg == ST_RUN))
        else $error("in-range compute did not start the sequencer");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg <= inner_reg))
        else $error("term counter ran past inner size");

    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!rd_vld_reg && !mul_vld_reg))
        else $error("result taken before the MAC pipeline drained");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_OUT_RANGE)) |-> (product_reg == '0))
        else $error("out-of-range result carries a non-zero product");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> (!done_load && !start_err))
        else $error("held result overwritten");
`endif

endmodule

### sim/dense_matrix_multiply_test.sv
// Self-checking testbench for the dense matrix multiply block.
`timescale 1ns / 1ps

module dense_matrix_multiply_test;

    import dmm_pkg::*;

    localparam int               DIM_MAX    = MAX_DIM_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int               IDLE_PCT   = 18;
    localparam int               HOLD_LEN   = 400;
    localparam int               SETTLE     = 40;   // well past the longest compute
    localparam int               PHASE_LEN  = 150;
    localparam int               NUM_PHASES = 8;

    // One input transaction as the driver presents it
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         r;
        logic [IDX_W-1:0]         c;
        logic signed [ELEM_W-1:0] v;
    } matrix_cmd_t;

    // One product element as the block should return it
    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic                     status;
    } dot_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DIM_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         command = '0;
    logic [IDX_W-1:0]         row = '0;
    logic [IDX_W-1:0]         col = '0;
    logic signed [ELEM_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [PROD_W-1:0] product;
    logic                     status;

    // Stimulus side
    matrix_cmd_t commands_waiting[$];
    int          queued_count = 0;
    int          useful_items = 0;      // writes that land, and computes
    bit          a_set[0:DIM_MAX*DIM_MAX-1];
    bit          b_set[0:DIM_MAX*DIM_MAX-1];
    bit          calm = 1'b0;           // no idling on either side while set
    int          hold_requests = 0;

    // Predictor state: own copy of the sizes and both stores
    logic [DIM_W-1:0]         dim_rows = DIM_W'(DIM_MAX);
    logic [DIM_W-1:0]         dim_inner = DIM_W'(DIM_MAX);
    logic [DIM_W-1:0]         dim_cols = DIM_W'(DIM_MAX);
    logic signed [ELEM_W-1:0] a_mem[0:DIM_MAX*DIM_MAX-1];
    logic signed [ELEM_W-1:0] b_mem[0:DIM_MAX*DIM_MAX-1];
    dot_result_t              sums_due[$];
    int                       accepted_count = 0;
    bit                       in_taken = 1'b0;

    // Receiver side
    int          holds_served = 0;
    int          hold_left = 0;

    int          mismatches = 0;
    dot_result_t due;

    dense_matrix_multiply DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .product   (product),
        .status    (status)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------------------------
    // Predictor helpers
    // ---------------------------------------------------------------------------------

    // Size register as the block sees it: zero reads as one, big values saturate
    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] d);
        if (d == '0)
            return DIM_W'(1);
        if (int'(d) > DIM_MAX)
            return DIM_W'(DIM_MAX);
        return d;
    endfunction

    function automatic bit a_fits(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        return (r < dim_rows) && (c < dim_inner);
    endfunction

    function automatic bit b_fits(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        return (r < dim_inner) && (c < dim_cols);
    endfunction

    function automatic bit outside(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        return (r >= dim_rows) || (c >= dim_cols);
    endfunction

    // Exact Q24.16 dot product of A row r and B column c over inner_size terms
    function automatic logic signed [PROD_W-1:0] dot_product_of(input logic [IDX_W-1:0] r,
                                                               input logic [IDX_W-1:0] c);
        logic signed [PROD_W-1:0] acc;
        logic signed [MUL_W-1:0]  term;
        acc = '0;
        for (int k = 0; k < int'(dim_inner); k++) begin
            term = a_mem[{r, IDX_W'(k)}] * b_mem[{IDX_W'(k), c}];
            acc  = acc + term;
        end
        return acc;
    endfunction

    // Apply one accepted transaction to the predictor's state
    task automatic take_item(input matrix_cmd_t t);
        case (t.cmd)
            CMD_WRITE_A: if (a_fits(t.r, t.c)) a_mem[{t.r, t.c}] = t.v;
            CMD_WRITE_B: if (b_fits(t.r, t.c)) b_mem[{t.r, t.c}] = t.v;
            CMD_COMPUTE:
                if (outside(t.r, t.c))
                    sums_due.push_back('{product: '0, status: STATUS_OUT_RANGE});
                else
                    sums_due.push_back('{product: dot_product_of(t.r, t.c),
                                         status: STATUS_OK});
            default: ;  // unused command: no effect, no result
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------------------------
    // Input side: sample accepted transactions and register writes at the rising edge
    // ---------------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken <= 1'b0;
        end
        else begin
            in_taken <= in_valid && in_ready;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROWS_A:     dim_rows  = limit_dim(cfg_data);
                    CFG_INNER_SIZE: dim_inner = limit_dim(cfg_data);
                    CFG_COLS_B:     dim_cols  = limit_dim(cfg_data);
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                accepted_count++;
                take_item('{cmd: command, r: row, c: col, v: value});
            end
        end
    end

    // Driver: presents the next pending item at the falling edge once the last one
    // has gone; valid is never withdrawn before its transaction completes.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken) begin
            if (commands_waiting.size() > 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                matrix_cmd_t t;
                t = commands_waiting.pop_front();
                command  <= t.cmd;
                row      <= t.r;
                col      <= t.c;
                value    <= t.v;
                in_valid <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Output side: random back-pressure, plus a long hold-off on request so the block
    // fills up and refuses input
    // ---------------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_LEN;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every result transaction is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (sums_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result product %0d status %0d",
                                        product, status));
            end
            else begin
                due = sums_due.pop_front();
                if (product !== due.product)
                    flag_mismatch($sformatf("product %0d, wanted %0d", product, due.product));
                if (status !== due.status)
                    flag_mismatch($sformatf("status %0d, wanted %0d", status, due.status));
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------

    // Queue one item and track which store entries it will have written, so that
    // no compute ever reads an entry left undefined since reset
    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] v);
        commands_waiting.push_back('{cmd: cmd, r: r, c: c, v: v});
        queued_count++;
        case (cmd)
            CMD_WRITE_A:
                if (a_fits(r, c)) begin
                    a_set[{r, c}] = 1'b1;
                    useful_items++;
                end
            CMD_WRITE_B:
                if (b_fits(r, c)) begin
                    b_set[{r, c}] = 1'b1;
                    useful_items++;
                end
            CMD_COMPUTE: useful_items++;
            default: ;
        endcase
    endtask

    // Mostly random, with the Q8.8 extremes and zero well represented
    function automatic logic [ELEM_W-1:0] pick_value();
        int p;
        p = $urandom_range(99);
        if (p < 10)
            return 16'h8000;
        if (p < 20)
            return 16'h7fff;
        if (p < 25)
            return '0;
        return ELEM_W'($urandom);
    endfunction

    // Size register value: zero, one, full, above full, or anything between
    function automatic logic [DIM_W-1:0] pick_dim();
        int p;
        p = $urandom_range(99);
        if (p < 12)
            return '0;
        if (p < 22)
            return DIM_W'(1);
        if (p < 42)
            return DIM_W'(DIM_MAX);
        if (p < 52)
            return DIM_W'($urandom_range(31, DIM_MAX + 1));
        return DIM_W'($urandom_range(DIM_MAX, 1));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                            input logic [DIM_W-1:0] cols);
        write_reg(CFG_ROWS_A, rows);
        write_reg(CFG_INNER_SIZE, inner);
        write_reg(CFG_COLS_B, cols);
        @(negedge clk);
    endtask

    // Wait for every queued transaction to be taken and every result to arrive, then
    // give the block time to finish any trailing write
    task automatic drain_all();
        do
            @(negedge clk);
        while (accepted_count != queued_count || sums_due.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // One stimulus sequence: usually a complete load-and-compute of one element,
    // otherwise out-of-range computes, stray writes or the unused command
    task automatic plan_sequence();
        int               pick;
        int               extreme;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] k;
        pick = $urandom_range(99);
        if (pick < 70) begin
            r       = IDX_W'($urandom_range(int'(dim_rows) - 1));
            c       = IDX_W'($urandom_range(int'(dim_cols) - 1));
            extreme = $urandom_range(9);
            for (int i = 0; i < int'(dim_inner); i++) begin
                k = IDX_W'(i);
                // extreme sequences drive the sum to its largest and smallest values
                if (extreme == 0) begin
                    queue_item(CMD_WRITE_A, r, k, 16'h8000);
                    queue_item(CMD_WRITE_B, k, c, 16'h8000);
                end
                else if (extreme == 1) begin
                    queue_item(CMD_WRITE_A, r, k, 16'h8000);
                    queue_item(CMD_WRITE_B, k, c, 16'h7fff);
                end
                else begin
                    if (!a_set[{r, k}] || $urandom_range(9) == 0)
                        queue_item(CMD_WRITE_A, r, k, pick_value());
                    if (!b_set[{k, c}] || $urandom_range(9) == 0)
                        queue_item(CMD_WRITE_B, k, c, pick_value());
                end
            end
            queue_item(CMD_COMPUTE, r, c, ELEM_W'($urandom));
        end
        else if (pick < 80 && (int'(dim_rows) < DIM_MAX || int'(dim_cols) < DIM_MAX)) begin
            do begin
                r = IDX_W'($urandom);
                c = IDX_W'($urandom);
            end while (!outside(r, c));
            queue_item(CMD_COMPUTE, r, c, ELEM_W'($urandom));
        end
        else if (pick < 86) begin
            queue_item(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
        end
        else begin
            // stray write anywhere; it lands only when inside the sizes
            queue_item($urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A,
                       IDX_W'($urandom), IDX_W'($urandom), pick_value());
        end
    endtask

    task automatic run_phase(input bit quiet, input bit hold, input bit pause_midway);
        int stop_at;
        int pause_at;
        stop_at  = useful_items + PHASE_LEN;
        pause_at = useful_items + PHASE_LEN / 2;
        calm     = quiet;
        if (hold)
            hold_requests++;
        while (useful_items < stop_at) begin
            // sender goes quiet until every outstanding result is back
            if (pause_midway && useful_items >= pause_at) begin
                drain_all();
                pause_midway = 1'b0;
            end
            plan_sequence();
        end
        drain_all();
        calm = 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: 1x1x1 through zero-valued size registers, extremes of the
        // element range, writes and computes just outside the sizes, unused command
        set_dims('0, '0, '0);
        queue_item(CMD_WRITE_A, 4'd0, 4'd0, 16'h8000);
        queue_item(CMD_WRITE_B, 4'd0, 4'd0, 16'h8000);
        queue_item(CMD_COMPUTE, 4'd0, 4'd0, 16'h0000);
        queue_item(CMD_WRITE_A, 4'd0, 4'd0, 16'h7fff);
        queue_item(CMD_COMPUTE, 4'd0, 4'd0, 16'hffff);
        queue_item(CMD_WRITE_B, 4'd0, 4'd0, 16'h7fff);
        queue_item(CMD_COMPUTE, 4'd0, 4'd0, 16'h0000);
        queue_item(CMD_WRITE_A, 4'd1, 4'd0, 16'h0005);
        queue_item(CMD_WRITE_A, 4'd0, 4'd1, 16'h0005);
        queue_item(CMD_WRITE_B, 4'd1, 4'd0, 16'h0007);
        queue_item(CMD_WRITE_B, 4'd0, 4'd1, 16'h0007);
        queue_item(CMD_WRITE_A, 4'd15, 4'd15, 16'hffff);
        queue_item(CMD_COMPUTE, 4'd1, 4'd0, 16'h0000);
        queue_item(CMD_COMPUTE, 4'd0, 4'd1, 16'h0000);
        queue_item(CMD_COMPUTE, 4'd15, 4'd15, 16'hffff);
        queue_item(CMD_UNUSED, 4'd15, 4'd15, 16'hffff);
        queue_item(CMD_COMPUTE, 4'd0, 4'd0, 16'h0000);
        queue_item(CMD_WRITE_A, 4'd0, 4'd0, 16'h0000);
        queue_item(CMD_COMPUTE, 4'd0, 4'd0, 16'h0000);
        drain_all();

        // Random phases under varied sizes; the first saturates every register,
        // one runs without idling, one opens with a long receiver hold-off and
        // one pauses the sender halfway
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 0)
                set_dims(5'd31, 5'd31, 5'd31);
            else
                set_dims(pick_dim(), pick_dim(), pick_dim());
            run_phase(p == 2, p == 4, p == 3);
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
